>>> rtl/core/wfo_pkg.sv
`default_nettype none

package wfo_pkg;

    // fixed field widths
    localparam int FM_W      = 24;
    localparam int BASE_W    = 24;
    localparam int PPH_W     = 20;
    localparam int SHAPE_W   = 2;
    localparam int SAMPLE_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;
    localparam int FRAC_W    = 16;
    localparam int ROM_W     = 15;   // magnitude of a quarter-wave entry
    localparam int ENTRY_W   = 17;   // waveform entry, triangle peaks at +32768

    // register reset values
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(112640);
    localparam logic [PPH_W-1:0]  PPH_RESET  = PPH_W'(89478);

    typedef enum logic [SHAPE_W-1:0] {
        SHAPE_SINE   = 2'd0,
        SHAPE_SQUARE = 2'd1,
        SHAPE_SAW    = 2'd2,
        SHAPE_TRI    = 2'd3
    } t_shape;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_FREQ    = 2'd0,
        CFG_PHASE_PER_HZ = 2'd1,
        CFG_WAVE_SHAPE   = 2'd2
    } t_cfg_index;

    // per-stage load enables
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_pipe_en;

    // lookup stage result
    typedef struct packed {
        logic [ROM_W-1:0]          rom0;
        logic [ROM_W-1:0]          rom1;
        logic                      neg0;
        logic                      neg1;
        logic signed [ENTRY_W-1:0] calc0;
        logic signed [ENTRY_W-1:0] calc1;
        logic                      is_sine;
        logic [FRAC_W-1:0]         frac;
    } t_lookup;

endpackage

`default_nettype wire

>>> rtl/core/wfo_sine_rom.sv
`default_nettype none

module wfo_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [TABLE_BITS-2:0]         i_addr0,
    input  logic [TABLE_BITS-2:0]         i_addr1,
    output logic [wfo_pkg::ROM_W-1:0]     o_data0,
    output logic [wfo_pkg::ROM_W-1:0]     o_data1
);
    import wfo_pkg::*;

    localparam int QLEN = 2 ** (TABLE_BITS - 2);
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam longint unsigned SINE_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

    typedef logic [ROM_W-1:0] t_qrom [QLEN+1];

    // quarter-wave sine, taylor series in q30, rounded to q15
    function automatic logic [ROM_W-1:0] quarter_sine(input longint unsigned k);
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned r;
        x    = (k * TWO_PI_Q30) >> TABLE_BITS;
        term = x;
        sum  = x;
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x) >> 30) / SINE_DIV[n-1];
            term = (term * x) >> 30;
            if (n[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        r = (sum + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[ROM_W-1:0];
    endfunction

    function automatic t_qrom build_rom();
        t_qrom t;
        for (int k = 0; k <= QLEN; k++) begin
            t[k] = quarter_sine(longint'(k));
        end
        return t;
    endfunction

    localparam t_qrom QROM = build_rom();

    logic [ROM_W-1:0] r_data0;
    logic [ROM_W-1:0] r_data1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data0 <= QROM[i_addr0];
            r_data1 <= QROM[i_addr1];
        end
    end

    assign o_data0 = r_data0;
    assign o_data1 = r_data1;

endmodule

`default_nettype wire

>>> rtl/core/wfo_lookup.sv
`default_nettype none

module wfo_lookup #(
    parameter int TABLE_BITS = 10
) (
    input  logic                          i_clk,
    input  wfo_pkg::t_pipe_en             i_en,
    input  logic [TABLE_BITS-1:0]         i_index,
    input  logic [wfo_pkg::FRAC_W-1:0]    i_frac,
    input  wfo_pkg::t_shape               i_shape,
    output wfo_pkg::t_lookup              o_lk
);
    import wfo_pkg::*;

    localparam int ADDR_W   = TABLE_BITS - 1;
    localparam int QLEN     = 2 ** (TABLE_BITS - 2);
    localparam int UP_SHIFT = 16 - TABLE_BITS;

    localparam logic signed [ENTRY_W-1:0] SQ_HI    = 17'sd32767;
    localparam logic signed [ENTRY_W-1:0] SQ_LO    = -17'sd32768;
    localparam logic signed [ENTRY_W-1:0] SAW_OFS  = 17'sd32768;
    localparam logic signed [17:0]        TRI_RISE = 18'sd32768;
    localparam logic signed [17:0]        TRI_FALL = 18'sd98304;

    // mirrored quarter-wave address
    function automatic logic [ADDR_W-1:0] rom_addr(input logic [TABLE_BITS-1:0] idx);
        logic [ADDR_W-1:0] r;
        r = ADDR_W'(idx[TABLE_BITS-3:0]);
        return idx[TABLE_BITS-2] ? (ADDR_W'(QLEN) - r) : r;
    endfunction

    // square, sawtooth and triangle values straight from the index
    function automatic logic signed [ENTRY_W-1:0] calc_entry(
        input logic [TABLE_BITS-1:0] idx,
        input t_shape                shape
    );
        logic [15:0]              up;
        logic signed [17:0]       dbl;
        logic signed [17:0]       tri_v;
        logic                     lower;
        logic signed [ENTRY_W-1:0] v;
        up    = 16'(idx) << UP_SHIFT;
        dbl   = $signed({1'b0, up, 1'b0});
        lower = !idx[TABLE_BITS-1];
        tri_v = lower ? (dbl - TRI_RISE) : (TRI_FALL - dbl);
        case (shape)
            SHAPE_SQUARE: v = lower ? SQ_HI : SQ_LO;
            SHAPE_SAW:    v = $signed({1'b0, up}) - SAW_OFS;
            SHAPE_TRI:    v = tri_v[ENTRY_W-1:0];
            default:      v = '0;
        endcase
        return v;
    endfunction

    logic [TABLE_BITS-1:0] index1;
    logic [ROM_W-1:0]      rom_d0;
    logic [ROM_W-1:0]      rom_d1;

    logic                      r_neg0;
    logic                      r_neg1;
    logic signed [ENTRY_W-1:0] r_calc0;
    logic signed [ENTRY_W-1:0] r_calc1;
    logic                      r_is_sine;
    logic [FRAC_W-1:0]         r_frac;

    // following entry wraps to zero
    assign index1 = TABLE_BITS'(i_index + 1'b1);

    wfo_sine_rom #(
        .TABLE_BITS (TABLE_BITS)
    ) u_rom (
        .i_clk   (i_clk),
        .i_en    (i_en.s2),
        .i_addr0 (rom_addr(i_index)),
        .i_addr1 (rom_addr(index1)),
        .o_data0 (rom_d0),
        .o_data1 (rom_d1)
    );

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_neg0    <= i_index[TABLE_BITS-1];
            r_neg1    <= index1[TABLE_BITS-1];
            r_calc0   <= calc_entry(i_index, i_shape);
            r_calc1   <= calc_entry(index1, i_shape);
            r_is_sine <= (i_shape == SHAPE_SINE);
            r_frac    <= i_frac;
        end
    end

    assign o_lk.rom0    = rom_d0;
    assign o_lk.rom1    = rom_d1;
    assign o_lk.neg0    = r_neg0;
    assign o_lk.neg1    = r_neg1;
    assign o_lk.calc0   = r_calc0;
    assign o_lk.calc1   = r_calc1;
    assign o_lk.is_sine = r_is_sine;
    assign o_lk.frac    = r_frac;

endmodule

`default_nettype wire

>>> rtl/core/wfo_interp.sv
`default_nettype none

module wfo_interp (
    input  logic                          i_clk,
    input  wfo_pkg::t_pipe_en             i_en,
    input  wfo_pkg::t_lookup              i_lk,
    output logic [wfo_pkg::SAMPLE_W-1:0]  o_sample
);
    import wfo_pkg::*;

    localparam logic signed [19:0] SAT_HI = 20'sd32767;
    localparam logic signed [19:0] SAT_LO = -20'sd32768;
    localparam logic signed [34:0] RND    = 35'sd32768;

    logic signed [ENTRY_W-1:0] sine0;
    logic signed [ENTRY_W-1:0] sine1;
    logic signed [ENTRY_W-1:0] e0;
    logic signed [ENTRY_W-1:0] e1;
    logic signed [34:0]        rnd;
    logic signed [18:0]        adj;
    logic signed [19:0]        v;
    logic [SAMPLE_W-1:0]       n_sample;

    logic signed [ENTRY_W-1:0] r_e0_a;
    logic signed [17:0]        r_diff;
    logic [FRAC_W-1:0]         r_frac;
    logic signed [ENTRY_W-1:0] r_e0_b;
    logic signed [34:0]        r_prod;
    logic [SAMPLE_W-1:0]       r_sample;

    assign sine0 = i_lk.neg0 ? -$signed({2'b00, i_lk.rom0}) : $signed({2'b00, i_lk.rom0});
    assign sine1 = i_lk.neg1 ? -$signed({2'b00, i_lk.rom1}) : $signed({2'b00, i_lk.rom1});
    assign e0    = i_lk.is_sine ? sine0 : i_lk.calc0;
    assign e1    = i_lk.is_sine ? sine1 : i_lk.calc1;

    // e0 + floor(((e1 - e0) * f + 32768) / 65536), same as the two-tap blend
    assign rnd = r_prod + RND;
    assign adj = rnd[34:16];
    assign v   = 20'(r_e0_b) + 20'(adj);

    always_comb begin
        if (v > SAT_HI) begin
            n_sample = SAT_HI[SAMPLE_W-1:0];
        end else if (v < SAT_LO) begin
            n_sample = SAT_LO[SAMPLE_W-1:0];
        end else begin
            n_sample = v[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_e0_a <= e0;
            r_diff <= 18'(e1) - 18'(e0);
            r_frac <= i_lk.frac;
        end
        if (i_en.s4) begin
            r_e0_b <= r_e0_a;
            r_prod <= r_diff * $signed({1'b0, r_frac});
        end
        if (i_en.s5) begin
            r_sample <= n_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

`default_nettype wire

>>> rtl/core/wfo_phase.sv
`default_nettype none

module wfo_phase #(
    parameter int PHASE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic signed [wfo_pkg::FM_W-1:0]   i_fm,
    input  logic [wfo_pkg::BASE_W-1:0]        i_base,
    input  logic [wfo_pkg::PPH_W-1:0]         i_pph,
    output logic [PHASE_BITS-1:0]             o_phase
);
    import wfo_pkg::*;

    logic signed [25:0]      freq;
    logic signed [46:0]      prod;
    logic signed [38:0]      step;
    logic [PHASE_BITS-1:0]   n_phase;
    logic [PHASE_BITS-1:0]   r_phase;

    assign freq    = $signed({2'b00, i_base}) + 26'(i_fm);
    assign prod    = freq * $signed({1'b0, i_pph});
    // arithmetic shift floors, so a negative step wraps the phase backward
    assign step    = prod[46:8];
    assign n_phase = r_phase + PHASE_BITS'(step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
        end
    end

    assign o_phase = r_phase;

endmodule

`default_nettype wire

>>> rtl/core/wavetable_fm_oscillator_top.sv
// wavetable oscillator with additive frequency modulation
//
// s_axis: one beat per audio tick, tdata[23:0] = fm_offset (signed hz, 8 fraction bits)
// m_axis: one beat per input beat, tdata[15:0] = sample (signed q1.15)
// cfg:    i_cfg_we writes i_cfg_data into register i_cfg_index at the clock edge:
//         0 base_frequency, 1 phase_per_hz, 2 wave_shape; index 3 is ignored
//
// throughput is one beat per cycle while m_axis_tready is high; the phase
// accumulator update (one 26x21 multiply and add) is combinational into the
// phase register; a beat reaches m_axis_tvalid through five register stages:
// input register, registered sine rom read, blend setup, blend multiply,
// saturate into the output register
// the sample uses the phase before this beat's step is added
// each stage has its own valid bit, so a stalled receiver only backs up the
// pipeline once every stage holds a beat; bubbles keep filling meanwhile
// reset (synchronous, active low) clears the phase, the valid bits and loads
// 440 hz, a 48 khz step and the sine shape; no rom fill is needed
`default_nettype none

module wavetable_fm_oscillator_top #(
    parameter int TABLE_BITS = 10,
    parameter int PHASE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [23:0]                        s_axis_tdata,   // [23:0] fm_offset
    // master side
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [15:0]                        m_axis_tdata,   // [15:0] sample
    // register writes
    input  logic                               i_cfg_we,
    input  logic [wfo_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wfo_pkg::CFG_W-1:0]          i_cfg_data
);
    import wfo_pkg::*;

    // register file
    logic [BASE_W-1:0] r_base_freq;
    logic [PPH_W-1:0]  r_phase_per_hz;
    t_shape            r_wave_shape;

    // pipeline valid bits and input register
    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic              r_v4;
    logic              r_v5;
    logic signed [FM_W-1:0] r_fm;

    // per-stage ready: a stage can load when empty or when it is moving on
    logic ready1;
    logic ready2;
    logic ready3;
    logic ready4;
    logic ready5;
    t_pipe_en en;

    logic [PHASE_BITS-1:0]     phase;
    logic [TABLE_BITS-1:0]     index;
    logic [FRAC_W-1:0]         frac;
    logic [PHASE_BITS+15:0]    phase_ext;
    t_lookup                   lk;

    assign ready5 = !r_v5 || m_axis_tready;
    assign ready4 = !r_v4 || ready5;
    assign ready3 = !r_v3 || ready4;
    assign ready2 = !r_v2 || ready3;
    assign ready1 = !r_v1 || ready2;

    assign en.s2 = ready2;
    assign en.s3 = ready3;
    assign en.s4 = ready4;
    assign en.s5 = ready5;

    assign s_axis_tready = ready1;
    assign m_axis_tvalid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_v3           <= 1'b0;
            r_v4           <= 1'b0;
            r_v5           <= 1'b0;
            r_base_freq    <= BASE_RESET;
            r_phase_per_hz <= PPH_RESET;
            r_wave_shape   <= SHAPE_SINE;
        end else begin
            if (ready1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
            if (ready4) begin
                r_v4 <= r_v3;
            end
            if (ready5) begin
                r_v5 <= r_v4;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BASE_FREQ:    r_base_freq    <= i_cfg_data[BASE_W-1:0];
                    CFG_PHASE_PER_HZ: r_phase_per_hz <= i_cfg_data[PPH_W-1:0];
                    CFG_WAVE_SHAPE:   r_wave_shape   <= t_shape'(i_cfg_data[SHAPE_W-1:0]);
                    default:          ;
                endcase
            end
        end
    end

    // input register, payload only
    always_ff @(posedge i_clk) begin
        if (ready1) begin
            r_fm <= $signed(s_axis_tdata[FM_W-1:0]);
        end
    end

    // phase steps when the beat in the input register moves into the lookup
    wfo_phase #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (r_v1 && ready2),
        .i_fm    (r_fm),
        .i_base  (r_base_freq),
        .i_pph   (r_phase_per_hz),
        .o_phase (phase)
    );

    // top bits index the table, next 16 bits (zero filled if short) blend
    assign phase_ext = {phase, 16'h0000};
    assign index     = phase[PHASE_BITS-1 -: TABLE_BITS];
    assign frac      = phase_ext[PHASE_BITS-TABLE_BITS+15 -: FRAC_W];

    wfo_lookup #(
        .TABLE_BITS (TABLE_BITS)
    ) u_lookup (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_index (index),
        .i_frac  (frac),
        .i_shape (r_wave_shape),
        .o_lk    (lk)
    );

    wfo_interp u_interp (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_lk     (lk),
        .o_sample (m_axis_tdata)
    );

endmodule

`default_nettype wire
